FILE: rtl/core/vurp_pkg.sv
// Shared types, codes and address helpers of the video unit register port.
package vurp_pkg;

  localparam int NT_BYTES  = 2048;
  localparam int NT_AW     = $clog2(NT_BYTES);
  localparam int SPR_DEPTH = 256;
  localparam int PAL_DEPTH = 32;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_STATUS = 2'd2,
    OP_NMI    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef enum logic [1:0] {
    MIR_HORIZONTAL = 2'd0,
    MIR_VERTICAL   = 2'd1,
    MIR_SINGLE_LO  = 2'd2,
    MIR_SINGLE_HI  = 2'd3
  } mirror_t;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  function automatic logic [10:0] nt_index(input logic [1:0] mode, input logic [13:0] addr);
    logic hi;
    case (mirror_t'(mode))
      MIR_HORIZONTAL: hi = addr[11];
      MIR_VERTICAL:   hi = addr[10];
      MIR_SINGLE_LO:  hi = 1'b0;
      MIR_SINGLE_HI:  hi = 1'b1;
      default:        hi = 1'b0;
    endcase
    return {hi, addr[9:0]};
  endfunction

  function automatic logic [4:0] pal_index(input logic [13:0] addr);
    logic [4:0] a;
    a = addr[4:0];
    if (a[4] && (a[1:0] == 2'b00)) begin
      a[4] = 1'b0;
    end
    return a;
  endfunction

endpackage

FILE: rtl/core/video_unit_register_port.sv
// Top level: CPU register port of the video unit with sprite, nametable and palette memories.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | operation, reg_index, write_data, status_flags
//  out_    | output    | out_valid / out_stall | read_data, nmi, pattern_access/write/address/data
//  cfg_    | input     | cfg_wr_en             | wr_data (mirroring mode)
//
//  The accept edge reads the memories; the edge that leaves the execute state writes back
//  and loads the output register. A new word is accepted while the previous result waits.
//  After reset a clearing pass over every nametable address fills the memories; in_stall is high then.
//  A stalled output holds the word in the execute state until the output register frees.
module video_unit_register_port (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_write_data,
  input  logic [2:0]  in_status_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_nmi,
  output logic        out_pattern_access,
  output logic        out_pattern_write,
  output logic [12:0] out_pattern_address,
  output logic [7:0]  out_pattern_data
);

  vurp_pkg::state_t state_r, state_nxt;
  logic [vurp_pkg::NT_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]  mirroring_r;

  vurp_pkg::op_t op_r;
  logic [2:0]  reg_r;
  logic [7:0]  data_r;
  logic [2:0]  flags_r;

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  rbuf_r, rbuf_nxt;
  logic [7:0]  spr_addr_r, spr_addr_nxt;
  logic [14:0] cur_v_r, cur_v_nxt;
  logic [14:0] tmp_v_r, tmp_v_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic        toggle_r, toggle_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_rd_r, res_rd;
  logic        out_nmi_r, res_nmi;
  logic        out_pacc_r, res_pacc;
  logic        out_pwr_r, res_pwr;
  logic [12:0] out_paddr_r, res_paddr;
  logic [7:0]  out_pdat_r, res_pdat;

  logic [7:0] nt_mem [vurp_pkg::NT_BYTES];
  logic [7:0] pal_mem [vurp_pkg::PAL_DEPTH];
  logic [7:0] spr_mem [vurp_pkg::SPR_DEPTH];
  logic [7:0] nt_rdata_r, pal_rdata_r, spr_rdata_r;

  logic        accept, clearing, finish;
  logic [13:0] vaddr;
  logic [13:0] v_step;
  logic [10:0] nt_idx;
  logic [4:0]  pal_idx;
  logic        is_pat, is_pal;
  logic        data_wr;
  logic        nt_we, pal_we, spr_we;
  logic [vurp_pkg::NT_AW-1:0] nt_wa;
  logic [4:0]  pal_wa;
  logic [7:0]  spr_wa;
  logic [7:0]  nt_wd, pal_wd, spr_wd;

  assign vaddr   = cur_v_r[13:0];
  assign nt_idx  = vurp_pkg::nt_index(mirroring_r, vaddr);
  assign pal_idx = vurp_pkg::pal_index(vaddr);
  assign is_pat  = ~vaddr[13];
  assign is_pal  = (vaddr[13:8] == 6'h3F);
  assign v_step  = vaddr + (ctrl_r[2] ? 14'd32 : 14'd1);

  assign clearing = (state_r == vurp_pkg::ST_CLEAR);
  assign accept   = in_valid && !in_stall;
  assign data_wr  = (op_r == vurp_pkg::OP_WRITE) && (reg_r == vurp_pkg::REG_DATA);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_stall    = 1'b1;
    finish      = 1'b0;
    case (state_r)
      vurp_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == vurp_pkg::NT_AW'(vurp_pkg::NT_BYTES - 1)) begin
          state_nxt = vurp_pkg::ST_IDLE;
        end
      end
      vurp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = vurp_pkg::ST_EXEC;
        end
      end
      vurp_pkg::ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          finish    = 1'b1;
          state_nxt = vurp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vurp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    rbuf_nxt     = rbuf_r;
    spr_addr_nxt = spr_addr_r;
    cur_v_nxt    = cur_v_r;
    tmp_v_nxt    = tmp_v_r;
    fine_x_nxt   = fine_x_r;
    toggle_nxt   = toggle_r;
    res_rd       = 8'd0;
    res_nmi      = 1'b0;
    res_pacc     = 1'b0;
    res_pwr      = 1'b0;
    res_paddr    = 13'd0;
    res_pdat     = 8'd0;
    case (op_r)
      vurp_pkg::OP_READ: begin
        case (reg_r)
          vurp_pkg::REG_STATUS: begin
            res_rd     = {status_r, rbuf_r[4:0]};
            status_nxt = {1'b0, status_r[1:0]};
            toggle_nxt = 1'b0;
          end
          vurp_pkg::REG_OAM_DATA: begin
            res_rd = spr_rdata_r;
          end
          vurp_pkg::REG_DATA: begin
            res_rd = rbuf_r;
            if (is_pat) begin
              res_pacc  = 1'b1;
              res_paddr = vaddr[12:0];
              rbuf_nxt  = 8'd0;
            end else if (!is_pal) begin
              rbuf_nxt = nt_rdata_r;
            end else begin
              rbuf_nxt = pal_rdata_r;
              res_rd   = pal_rdata_r;
            end
            cur_v_nxt = {1'b0, v_step};
          end
          default: begin
          end
        endcase
      end
      vurp_pkg::OP_WRITE: begin
        case (reg_r)
          vurp_pkg::REG_CTRL: begin
            ctrl_nxt         = data_r;
            tmp_v_nxt[11:10] = data_r[1:0];
          end
          vurp_pkg::REG_MASK: begin
            mask_nxt = data_r;
          end
          vurp_pkg::REG_OAM_ADDR: begin
            spr_addr_nxt = data_r;
          end
          vurp_pkg::REG_OAM_DATA: begin
            spr_addr_nxt = spr_addr_r + 8'd1;
          end
          vurp_pkg::REG_SCROLL: begin
            if (!toggle_r) begin
              fine_x_nxt     = data_r[2:0];
              tmp_v_nxt[4:0] = data_r[7:3];
            end else begin
              tmp_v_nxt[14:12] = data_r[2:0];
              tmp_v_nxt[9:5]   = data_r[7:3];
            end
            toggle_nxt = ~toggle_r;
          end
          vurp_pkg::REG_ADDR: begin
            if (!toggle_r) begin
              tmp_v_nxt[14:8] = {1'b0, data_r[5:0]};
            end else begin
              tmp_v_nxt = {tmp_v_r[14:8], data_r};
              cur_v_nxt = {tmp_v_r[14:8], data_r};
            end
            toggle_nxt = ~toggle_r;
          end
          vurp_pkg::REG_DATA: begin
            if (is_pat) begin
              res_pacc  = 1'b1;
              res_pwr   = 1'b1;
              res_paddr = vaddr[12:0];
              res_pdat  = data_r;
            end
            cur_v_nxt = {1'b0, v_step};
          end
          default: begin
          end
        endcase
      end
      vurp_pkg::OP_STATUS: begin
        status_nxt = flags_r;
      end
      vurp_pkg::OP_NMI: begin
        res_nmi = ctrl_r[7];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    nt_we  = clearing || (finish && data_wr && !is_pat && !is_pal);
    pal_we = clearing || (finish && data_wr && is_pal);
    spr_we = clearing || (finish && (op_r == vurp_pkg::OP_WRITE)
                          && (reg_r == vurp_pkg::REG_OAM_DATA));
    nt_wa  = clearing ? clr_cnt_r : vurp_pkg::NT_AW'(nt_idx);
    pal_wa = clearing ? clr_cnt_r[4:0] : pal_idx;
    spr_wa = clearing ? clr_cnt_r[7:0] : spr_addr_r;
    nt_wd  = clearing ? 8'h00 : data_r;
    pal_wd = clearing ? 8'h00 : data_r;
    spr_wd = clearing ? 8'hFF : data_r;
  end

  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_mem[nt_wa] <= nt_wd;
    end
    if (accept) begin
      nt_rdata_r <= nt_mem[vurp_pkg::NT_AW'(nt_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_wa] <= pal_wd;
    end
    if (accept) begin
      pal_rdata_r <= pal_mem[pal_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (spr_we) begin
      spr_mem[spr_wa] <= spr_wd;
    end
    if (accept) begin
      spr_rdata_r <= spr_mem[spr_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vurp_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      mirroring_r <= 2'd0;
      ctrl_r      <= 8'd0;
      mask_r      <= 8'd0;
      status_r    <= 3'd0;
      rbuf_r      <= 8'd0;
      spr_addr_r  <= 8'd0;
      cur_v_r     <= 15'd0;
      tmp_v_r     <= 15'd0;
      fine_x_r    <= 3'd0;
      toggle_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mirroring_r <= cfg_wr_data;
      end
      if (finish) begin
        ctrl_r     <= ctrl_nxt;
        mask_r     <= mask_nxt;
        status_r   <= status_nxt;
        rbuf_r     <= rbuf_nxt;
        spr_addr_r <= spr_addr_nxt;
        cur_v_r    <= cur_v_nxt;
        tmp_v_r    <= tmp_v_nxt;
        fine_x_r   <= fine_x_nxt;
        toggle_r   <= toggle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= vurp_pkg::op_t'(in_operation);
      reg_r   <= in_reg_index;
      data_r  <= in_write_data;
      flags_r <= in_status_flags;
    end
    if (finish) begin
      out_rd_r    <= res_rd;
      out_nmi_r   <= res_nmi;
      out_pacc_r  <= res_pacc;
      out_pwr_r   <= res_pwr;
      out_paddr_r <= res_paddr;
      out_pdat_r  <= res_pdat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_rd_r;
  assign out_nmi             = out_nmi_r;
  assign out_pattern_access  = out_pacc_r;
  assign out_pattern_write   = out_pwr_r;
  assign out_pattern_address = out_paddr_r;
  assign out_pattern_data    = out_pdat_r;

endmodule

FILE: rtl/core/vurp_checker.sv
// Port-level checker of the video unit register port, bound to the top level.
module vurp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_data,
  input logic        out_nmi,
  input logic        out_pattern_access,
  input logic        out_pattern_write,
  input logic [12:0] out_pattern_address,
  input logic [7:0]  out_pattern_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_nmi)
      && $stable(out_pattern_address) && $stable(out_pattern_data))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in execution");

  a_pattern_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pattern_write |-> out_pattern_access)
    else $error("pattern write without pattern access");

  a_pattern_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pattern_access |-> out_pattern_address == 13'd0
      && out_pattern_data == 8'd0)
    else $error("pattern fields set without pattern access");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("port open right after reset");

endmodule

bind video_unit_register_port vurp_checker u_vurp_checker (.*);

FILE: verif/video_unit_register_port_tb.sv
// Self-checking testbench for the video unit register port: directed corners, then random traffic.
module video_unit_register_port_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vurp_pkg::*;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi;
    logic        pattern_access;
    logic        pattern_write;
    logic [12:0] pattern_address;
    logic [7:0]  pattern_data;
  } vu_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = 2'd0;
  logic [2:0]  in_reg_index = 3'd0;
  logic [7:0]  in_write_data = 8'd0;
  logic [2:0]  in_status_flags = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_nmi;
  logic        out_pattern_access;
  logic        out_pattern_write;
  logic [12:0] out_pattern_address;
  logic [7:0]  out_pattern_data;

  video_unit_register_port i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_reg_index        (in_reg_index),
    .in_write_data       (in_write_data),
    .in_status_flags     (in_status_flags),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_nmi             (out_nmi),
    .out_pattern_access  (out_pattern_access),
    .out_pattern_write   (out_pattern_write),
    .out_pattern_address (out_pattern_address),
    .out_pattern_data    (out_pattern_data)
  );

  mirror_t     mirror_q;
  logic [7:0]  ctrl_q;
  logic [7:0]  mask_q;
  logic [2:0]  status_q;
  logic [7:0]  rbuf;
  logic [7:0]  oam_addr;
  logic [7:0]  oam_mem [SPR_DEPTH];
  logic [14:0] vaddr;
  logic [14:0] taddr;
  logic [2:0]  fine_x;
  logic        toggle;
  logic [7:0]  nt_mem [NT_BYTES];
  logic [7:0]  pal_mem [PAL_DEPTH];

  vu_result_t  pending_results[$];
  int unsigned words_sent;
  int unsigned useful_words;
  int unsigned results_checked;
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [10:0] nt_slot(logic [13:0] a);
    logic hi;
    case (mirror_q)
      MIR_HORIZONTAL: hi = a[11];
      MIR_VERTICAL:   hi = a[10];
      MIR_SINGLE_LO:  hi = 1'b0;
      default:        hi = 1'b1;
    endcase
    return {hi, a[9:0]};
  endfunction

  function automatic logic [4:0] pal_slot(logic [13:0] a);
    logic [4:0] p;
    p = a[4:0];
    if ((p & 5'h13) == 5'h10) begin
      p[4] = 1'b0;
    end
    return p;
  endfunction

  function automatic vu_result_t apply_access(op_t op, logic [2:0] idx, logic [7:0] data,
                                              logic [2:0] flags);
    vu_result_t  r;
    logic [13:0] a;
    logic [13:0] step;
    r = '0;
    a = vaddr[13:0];
    step = ctrl_q[2] ? 14'd32 : 14'd1;
    case (op)
      OP_READ: begin
        case (idx)
          REG_STATUS: begin
            r.read_data = {status_q, rbuf[4:0]};
            status_q[2] = 1'b0;
            toggle = 1'b0;
          end
          REG_OAM_DATA: r.read_data = oam_mem[oam_addr];
          REG_DATA: begin
            r.read_data = rbuf;
            if (a < 14'h2000) begin
              r.pattern_access = 1'b1;
              r.pattern_address = a[12:0];
              rbuf = 8'h00;
            end else if (a < 14'h3F00) begin
              rbuf = nt_mem[nt_slot(a)];
            end else begin
              rbuf = pal_mem[pal_slot(a)];
              r.read_data = rbuf;
            end
            vaddr = {1'b0, a + step};
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (idx)
          REG_CTRL: begin
            ctrl_q = data;
            taddr[11:10] = data[1:0];
          end
          REG_MASK: mask_q = data;
          REG_OAM_ADDR: oam_addr = data;
          REG_OAM_DATA: begin
            oam_mem[oam_addr] = data;
            oam_addr = oam_addr + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle) begin
              fine_x = data[2:0];
              taddr[4:0] = data[7:3];
            end else begin
              taddr[14:12] = data[2:0];
              taddr[9:5] = data[7:3];
            end
            toggle = ~toggle;
          end
          REG_ADDR: begin
            if (!toggle) begin
              taddr[14] = 1'b0;
              taddr[13:8] = data[5:0];
            end else begin
              taddr[7:0] = data;
              vaddr = taddr;
            end
            toggle = ~toggle;
          end
          REG_DATA: begin
            if (a < 14'h2000) begin
              r.pattern_access = 1'b1;
              r.pattern_write = 1'b1;
              r.pattern_address = a[12:0];
              r.pattern_data = data;
            end else if (a < 14'h3F00) begin
              nt_mem[nt_slot(a)] = data;
            end else begin
              pal_mem[pal_slot(a)] = data;
            end
            vaddr = {1'b0, a + step};
          end
          default: ;
        endcase
      end
      OP_STATUS: status_q = flags;
      default: r.nmi = ctrl_q[7];
    endcase
    return r;
  endfunction

  function automatic bit has_effect(op_t op, logic [2:0] idx);
    if (op == OP_READ) begin
      return idx inside {REG_STATUS, REG_OAM_DATA, REG_DATA};
    end
    return !(op == OP_WRITE && idx == REG_STATUS);
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    vu_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual read_data 0x%0h",
                 $time, out_read_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, out_read_data);
        if (out_nmi !== want.nmi)
          report_mismatch("nmi", want.nmi, out_nmi);
        if (out_pattern_access !== want.pattern_access)
          report_mismatch("pattern_access", want.pattern_access, out_pattern_access);
        if (out_pattern_write !== want.pattern_write)
          report_mismatch("pattern_write", want.pattern_write, out_pattern_write);
        if (out_pattern_address !== want.pattern_address)
          report_mismatch("pattern_address", want.pattern_address, out_pattern_address);
        if (out_pattern_data !== want.pattern_data)
          report_mismatch("pattern_data", want.pattern_data, out_pattern_data);
      end
    end
  end

  task automatic send_word(op_t op, logic [2:0] idx, logic [7:0] data, logic [2:0] flags);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_reg_index <= idx;
    in_write_data <= data;
    in_status_flags <= flags;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_access(op, idx, data, flags));
    words_sent++;
    if (has_effect(op, idx)) useful_words++;
  endtask

  task automatic reg_write(logic [2:0] idx, logic [7:0] data);
    send_word(OP_WRITE, idx, data, 3'($urandom));
  endtask

  task automatic reg_read(logic [2:0] idx);
    send_word(OP_READ, idx, 8'($urandom), 3'($urandom));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_mirroring(mirror_t mode);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mirror_q = mode;
  endtask

  task automatic set_vram_addr(logic [7:0] hi, logic [7:0] lo);
    if ($urandom_range(9) < 8) reg_read(REG_STATUS);
    reg_write(REG_ADDR, hi);
    reg_write(REG_ADDR, lo);
  endtask

  function automatic logic [7:0] pick_vram_high();
    logic [7:0] hi;
    hi = 8'($urandom);
    case ($urandom_range(3))
      0: hi[5] = 1'b0;
      1: hi[5:0] = 6'h20 + 6'($urandom_range(30));
      2: hi[5:0] = 6'h3F;
      default: ;
    endcase
    return hi;
  endfunction

  task automatic random_sequence();
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  base;
    int unsigned k;
    case ($urandom_range(11))
      0, 1, 2: begin
        set_vram_addr(pick_vram_high(), 8'($urandom));
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1)) reg_read(REG_DATA);
          else reg_write(REG_DATA, 8'($urandom));
        end
      end
      3, 4: begin
        hi = pick_vram_high();
        lo = 8'($urandom);
        k = $urandom_range(1, 6);
        set_vram_addr(hi, lo);
        repeat (k) reg_write(REG_DATA, 8'($urandom));
        set_vram_addr(hi, lo);
        repeat (k + 1) reg_read(REG_DATA);
      end
      5: begin
        reg_read(REG_STATUS);
        reg_write(REG_SCROLL, 8'($urandom));
        reg_write(REG_SCROLL, 8'($urandom));
        if ($urandom_range(1)) begin
          reg_write(REG_SCROLL, 8'($urandom));
          reg_write(REG_ADDR, 8'($urandom));
          reg_read(REG_DATA);
        end
      end
      6: begin
        base = 8'($urandom);
        k = $urandom_range(1, 4);
        reg_write(REG_OAM_ADDR, base);
        repeat (k) reg_write(REG_OAM_DATA, 8'($urandom));
        reg_write(REG_OAM_ADDR, 8'(base + $urandom_range(k)));
        reg_read(REG_OAM_DATA);
      end
      7: begin
        reg_write(REG_CTRL, 8'($urandom));
        send_word(OP_NMI, 3'($urandom), 8'($urandom), 3'($urandom));
      end
      8: begin
        send_word(OP_STATUS, 3'($urandom), 8'($urandom), 3'($urandom));
        reg_read(REG_STATUS);
      end
      9: begin
        reg_write(REG_MASK, 8'($urandom));
        reg_read(3'($urandom));
      end
      default: begin
        repeat ($urandom_range(1, 3))
          send_word(op_t'(2'($urandom)), 3'($urandom), 8'($urandom), 3'($urandom));
      end
    endcase
  endtask

  task automatic test_register_basics();
    reg_read(REG_OAM_DATA);
    send_word(OP_NMI, REG_CTRL, 8'h00, 3'd0);
    reg_write(REG_CTRL, 8'h80);
    send_word(OP_NMI, REG_CTRL, 8'hFF, 3'd7);
    send_word(OP_STATUS, REG_STATUS, 8'h00, 3'd7);
    reg_read(REG_STATUS);
    reg_read(REG_STATUS);
  endtask

  task automatic test_data_port_corners();
    reg_write(REG_ADDR, 8'h3F);
    reg_write(REG_ADDR, 8'h10);
    reg_write(REG_DATA, 8'hFF);
    reg_write(REG_ADDR, 8'h3F);
    reg_write(REG_ADDR, 8'h00);
    reg_read(REG_DATA);
    reg_write(REG_ADDR, 8'h1F);
    reg_write(REG_ADDR, 8'hFF);
    reg_write(REG_DATA, 8'hA5);
    reg_read(REG_DATA);
    reg_write(REG_CTRL, 8'h04);
    reg_write(REG_ADDR, 8'h3F);
    reg_write(REG_ADDR, 8'hFF);
    reg_read(REG_DATA);
    reg_read(REG_DATA);
    // hold fine Y at 7 so bit 14 of the address is set, then copy it over
    reg_write(REG_SCROLL, 8'h00);
    reg_write(REG_SCROLL, 8'h07);
    reg_write(REG_SCROLL, 8'h00);
    reg_write(REG_ADDR, 8'h00);
    reg_write(REG_DATA, 8'h5A);
    reg_write(REG_ADDR, 8'h20);
    reg_write(REG_ADDR, 8'h00);
    reg_read(REG_DATA);
    reg_read(REG_DATA);
  endtask

  task automatic test_random_phase(mirror_t mode, int unsigned send_pct, int unsigned rx_pct,
                                   int unsigned n);
    int unsigned goal;
    bit          paused;
    drain_results();
    set_mirroring(mode);
    send_idle_pct = send_pct;
    stall_pct = rx_pct;
    goal = useful_words + n;
    paused = 1'b0;
    while (useful_words < goal) begin
      if (!paused && useful_words + n / 2 >= goal) begin
        drain_results();
        paused = 1'b1;
      end
      random_sequence();
    end
  endtask

  initial begin
    mirror_q = MIR_HORIZONTAL;
    ctrl_q = '0;
    mask_q = '0;
    status_q = '0;
    rbuf = '0;
    oam_addr = '0;
    vaddr = '0;
    taddr = '0;
    fine_x = '0;
    toggle = 1'b0;
    foreach (oam_mem[i]) oam_mem[i] = 8'hFF;
    foreach (nt_mem[i]) nt_mem[i] = 8'h00;
    foreach (pal_mem[i]) pal_mem[i] = 8'h00;
    words_sent = 0;
    useful_words = 0;
    results_checked = 0;
    error_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_mirroring(MIR_HORIZONTAL);
    test_register_basics();
    test_data_port_corners();
    test_random_phase(MIR_HORIZONTAL, 0, 0, 350);
    test_random_phase(MIR_SINGLE_HI, 87, 0, 350);
    test_random_phase(MIR_VERTICAL, 0, 87, 350);
    test_random_phase(MIR_SINGLE_LO, 31, 31, 350);

    drain_results();
    stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("Covered %0d register accesses (%0d with effect) over all four mirroring modes,",
             words_sent, useful_words);
    $display("with and without sender gaps and output stalls; %0d results checked.",
             results_checked);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vurp_pkg.sv
rtl/core/video_unit_register_port.sv
rtl/core/vurp_checker.sv
verif/video_unit_register_port_tb.sv
